FILE: sv/mpbt_pkg.sv
//------------------------------------------------------------------------------
// mpbt_pkg
// Shared widths, defaults and the command/status bundles that join the
// controller and the datapath of the min-priority buffer table.
//------------------------------------------------------------------------------
`default_nettype none

package mpbt_pkg;

	localparam int TABLE_DEPTH_DEF = 8;
	localparam int SEQ_W           = 30;
	localparam int OCC_W           = 4;
	localparam int IN_DATA_W       = 32;
	localparam int OUT_DATA_W      = 40;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;       // latch the accepted word, append if push and room
		logic scan;        // step the minimum search
		logic shift_init;  // aim the read pointer just above the minimum slot
		logic shift;       // step the move-down of the upper entries
		logic write_min;   // overwrite the minimum slot with the pushed value
		logic out_load;    // load the result register and retire the pop
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic empty;
		logic mode_pop;
		logic scan_done;
		logic shift_done;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

FILE: sv/mpbt_ctrl.sv
//------------------------------------------------------------------------------
// mpbt_ctrl
// Controller state machine: sequences accept, minimum search, move-down,
// overwrite and result load for one word at a time.
//------------------------------------------------------------------------------
`default_nettype none

module mpbt_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            in_pop,
	output logic                 in_ready,
	input  wire mpbt_pkg::stat_t stat,
	output mpbt_pkg::cmd_t       cmd
);
	import mpbt_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_PREP  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_WRITE = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.start = 1'b1;
					if (in_pop) begin
						state_d = stat.empty ? S_OUT : S_SCAN;
					end else if (stat.full) begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					state_d = stat.mode_pop ? S_PREP : S_WRITE;
				end
			end
			S_PREP: begin
				cmd.shift_init = 1'b1;
				state_d        = S_SHIFT;
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				if (stat.shift_done) begin
					state_d = S_OUT;
				end
			end
			S_WRITE: begin
				cmd.write_min = 1'b1;
				state_d       = S_IDLE;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

FILE: sv/mpbt_dp.sv
//------------------------------------------------------------------------------
// mpbt_dp
// Datapath: entry memory, fill count, search and move-down pointers, running
// minimum and the result register.
//------------------------------------------------------------------------------
`default_nettype none

module mpbt_dp #(
	parameter int TABLE_DEPTH = mpbt_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mpbt_pkg::cmd_t                cmd,
	output mpbt_pkg::stat_t                    stat,
	input  wire logic                          in_mode,
	input  wire logic [mpbt_pkg::SEQ_W-1:0]    in_seq_value,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               out_found,
	output logic [mpbt_pkg::SEQ_W-1:0]         out_popped_value,
	output logic [mpbt_pkg::OCC_W-1:0]         out_occupancy
);
	import mpbt_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [SEQ_W-1:0] mem [TABLE_DEPTH];

	logic [CW-1:0]    fill_q;
	logic [CW-1:0]    ptr_q;
	logic             mode_q;
	logic [SEQ_W-1:0] value_q;
	logic             rv_q;
	logic [AW-1:0]    ri_q;
	logic [SEQ_W-1:0] rd_data_q;
	logic [SEQ_W-1:0] best_val_q;
	logic [AW-1:0]    best_idx_q;
	logic             out_valid_q;
	logic             found_q;
	logic [SEQ_W-1:0] popped_q;
	logic [OCC_W-1:0] occ_q;

	logic             full;
	logic             rd_en;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [SEQ_W-1:0] wr_data;
	logic [CW-1:0]    fill_dec;

	assign full     = (fill_q == CW'(TABLE_DEPTH));
	assign fill_dec = fill_q - CW'(1);
	assign rd_en    = (cmd.scan || cmd.shift) && (ptr_q < fill_q);

	assign stat.full       = full;
	assign stat.empty      = (fill_q == '0);
	assign stat.mode_pop   = mode_q;
	assign stat.scan_done  = (ptr_q == fill_q) && !rv_q;
	assign stat.shift_done = (ptr_q >= fill_q) && !rv_q;
	assign stat.out_free   = !out_valid_q || out_ready;

	// One memory write a cycle: append, overwrite of the minimum, or move-down.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = best_idx_q;
		wr_data = value_q;
		if (cmd.start && !in_mode && !full) begin
			wr_en   = 1'b1;
			wr_addr = fill_q[AW-1:0];
			wr_data = in_seq_value;
		end else if (cmd.write_min) begin
			wr_en   = 1'b1;
		end else if (cmd.shift && rv_q) begin
			wr_en   = 1'b1;
			wr_addr = ri_q - AW'(1);
			wr_data = rd_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[ptr_q[AW-1:0]];
			ri_q      <= ptr_q[AW-1:0];
		end
		if (cmd.start) begin
			mode_q  <= in_mode;
			value_q <= in_seq_value;
		end
		// The lowest slot wins on equal values, so only a strictly smaller one replaces.
		if (cmd.scan && rv_q && ((ri_q == '0) || (rd_data_q < best_val_q))) begin
			best_val_q <= rd_data_q;
			best_idx_q <= ri_q;
		end
		if (cmd.out_load) begin
			found_q  <= !stat.empty;
			popped_q <= stat.empty ? '0 : best_val_q;
			occ_q    <= stat.empty ? '0 : OCC_W'(fill_dec);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			ptr_q       <= '0;
			rv_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				ptr_q <= '0;
				rv_q  <= 1'b0;
				if (!in_mode && !full) begin
					fill_q <= fill_q + CW'(1);
				end
			end else if (cmd.shift_init) begin
				ptr_q <= CW'(best_idx_q) + CW'(1);
				rv_q  <= 1'b0;
			end else if (cmd.scan || cmd.shift) begin
				rv_q <= rd_en;
				if (rd_en) begin
					ptr_q <= ptr_q + CW'(1);
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				if (!stat.empty) begin
					fill_q <= fill_dec;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign out_found        = found_q;
	assign out_popped_value = popped_q;
	assign out_occupancy    = occ_q;

endmodule

`default_nettype wire

FILE: sv/min_priority_buffer_table_core.sv
//------------------------------------------------------------------------------
// min_priority_buffer_table_core
// Bounded table of buffer sequence numbers served smallest first; a push to a
// full table overwrites the smallest entry.
//
//   Channel  Dir  Fields (tdata, low bit up)
//   s_axis   in   mode[0], seq_value[30:1], zero[31]
//   m_axis   out  found[0], popped_value[30:1], occupancy[34:31], zero[39:35]
//
// A push with room is appended as it is accepted. A push to a full table
// runs a search that reads one entry a cycle from the single memory read
// port, then overwrites the minimum. A pop runs the search, the move-down of
// the upper entries through the same port, and the result load; a pop of an
// empty table goes straight to the result load. Reset empties the table at
// once. A result waiting on m_axis_tready holds the next pop at its result
// load; pushes continue meanwhile.
//------------------------------------------------------------------------------
`default_nettype none

module min_priority_buffer_table_core #(
	parameter int TABLE_DEPTH = mpbt_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [mpbt_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // mode, seq_value
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output logic [mpbt_pkg::OUT_DATA_W-1:0]        m_axis_tdata   // found, popped_value, occupancy
);
	import mpbt_pkg::*;

	cmd_t             cmd;
	stat_t            stat;
	logic             found;
	logic [SEQ_W-1:0] popped_value;
	logic [OCC_W-1:0] occupancy;

	mpbt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_pop   (s_axis_tdata[0]),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mpbt_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.in_mode          (s_axis_tdata[0]),
		.in_seq_value     (s_axis_tdata[SEQ_W:1]),
		.out_valid        (m_axis_tvalid),
		.out_ready        (m_axis_tready),
		.out_found        (found),
		.out_popped_value (popped_value),
		.out_occupancy    (occupancy)
	);

	assign m_axis_tdata = {
		{(OUT_DATA_W - 1 - SEQ_W - OCC_W){1'b0}}, occupancy, popped_value, found
	};

endmodule

`default_nettype wire
